// ===== rtl/dtrt_pkg.sv =====
package dtrt_pkg;

  // field widths of the command and run items
  localparam int COL_W  = 5;
  localparam int ROW_W  = 5;
  localparam int TILE_W = 9;
  localparam int LEN_W  = 5;

  // default grid size
  localparam int DEF_TILES_WIDE = 18;
  localparam int DEF_TILES_HIGH = 20;

  // command codes
  localparam logic CMD_MARK = 1'b0;
  localparam logic CMD_SCAN = 1'b1;

  // one run found by the row scanner
  typedef struct packed {
    logic [COL_W-1:0] start;
    logic [LEN_W-1:0] length;
    logic             last;
  } run_t;

  // row store write side controls
  typedef struct packed {
    logic we;
    logic clr;
  } mem_ctl_t;

endpackage

// ===== rtl/dtrt_cmd_if.sv =====
interface dtrt_cmd_if;
  import dtrt_pkg::*;

  logic             valid;
  logic             ready;
  logic             command;
  logic [COL_W-1:0] first_col;
  logic [ROW_W-1:0] top_row;
  logic [COL_W-1:0] last_col;
  logic [ROW_W-1:0] bottom_row;
  logic [ROW_W-1:0] scan_row;

  modport source (
    output valid, command, first_col, top_row, last_col, bottom_row, scan_row,
    input  ready
  );

  modport sink (
    input  valid, command, first_col, top_row, last_col, bottom_row, scan_row,
    output ready
  );

endinterface

// ===== rtl/dtrt_run_if.sv =====
interface dtrt_run_if;
  import dtrt_pkg::*;

  logic              valid;
  logic              ready;
  logic [TILE_W-1:0] run_first_tile;
  logic [LEN_W-1:0]  run_length;
  logic              row_empty;
  logic              last_run;

  modport source (
    output valid, run_first_tile, run_length, row_empty, last_run,
    input  ready
  );

  modport sink (
    input  valid, run_first_tile, run_length, row_empty, last_run,
    output ready
  );

endinterface

// ===== rtl/dirty_tile_run_tracker.sv =====
// Dirty tile run tracker: one dirty bit per tile, one memory word per tile row.
// cmd channel takes items: a mark sets the bits of a clamped tile rectangle and
// gives no result; a scan reads one row, clears it and gives its dirty runs.
// run channel gives one item per run, left to right, with its linear tile index
// and length; the final item of a scan has last_run set. A clean row, or a row
// beyond the grid, gives one item with row_empty set.
// One command is worked on at a time; cmd.ready is high only between commands.
// A mark does the read-modify-write of one row a cycle through the row memory,
// with the write of a row overlapping the read of the next. An empty rectangle
// is taken without any access to the row memory. A scan reads its row through
// the registered row memory; the column-serial run scanner then steps one
// column per cycle up to the end of the last run (at most TILES_WIDE), holding
// while a finished run cannot be taken; a clean row skips the scanner.
// Results go through an output register, so a stalled run channel holds the
// scanner but never loses an item; the next command is taken while the final
// result still waits.
// Reset clears the row valid bits at once, so every tile reads clean, and
// empties the output register.
module dirty_tile_run_tracker #(
  parameter int TILES_WIDE = dtrt_pkg::DEF_TILES_WIDE,
  parameter int TILES_HIGH = dtrt_pkg::DEF_TILES_HIGH
) (
  input logic        clk,
  input logic        rst,
  dtrt_cmd_if.sink   cmd,
  dtrt_run_if.source run
);
  import dtrt_pkg::*;

  localparam int RA = (TILES_HIGH > 1) ? $clog2(TILES_HIGH) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MARK,
    S_MARK_LAST,
    S_SCAN_RD,
    S_SCAN_LOAD,
    S_SCAN_RUN,
    S_EMPTY
  } state_t;

  state_t                state;
  logic [RA-1:0]         cur_row;
  logic [RA-1:0]         end_row;
  logic [RA-1:0]         pend_row;
  logic                  pend;
  logic [RA-1:0]         row_q;
  logic [TILE_W-1:0]     base_q;
  logic [TILES_WIDE-1:0] mark_mask;

  logic [COL_W-1:0]      c0;
  logic [COL_W-1:0]      c1;
  logic [RA-1:0]         r0;
  logic [RA-1:0]         r1;
  logic                  mark_empty;
  logic                  scan_oob;
  logic [TILE_W-1:0]     base_new;
  logic [TILES_WIDE-1:0] mask_new;

  mem_ctl_t              mem_ctl;
  logic [RA-1:0]         rd_addr;
  logic [RA-1:0]         wr_addr;
  logic [TILES_WIDE-1:0] wr_data;
  logic [TILES_WIDE-1:0] rd_data;

  logic                  scan_found;
  run_t                  scan_run;
  logic                  scan_start;

  logic                  out_valid;
  logic                  out_free;
  logic                  out_load;
  logic [TILE_W-1:0]     out_tile;
  logic [LEN_W-1:0]      out_len;
  logic                  out_empty;
  logic                  out_last;

  // clamp the rectangle corners to the grid
  always_comb begin
    c0 = (int'(cmd.first_col) > TILES_WIDE - 1) ? COL_W'(TILES_WIDE - 1) : cmd.first_col;
    c1 = (int'(cmd.last_col) > TILES_WIDE - 1) ? COL_W'(TILES_WIDE - 1) : cmd.last_col;
    r0 = (int'(cmd.top_row) > TILES_HIGH - 1) ? RA'(TILES_HIGH - 1) : RA'(cmd.top_row);
    r1 = (int'(cmd.bottom_row) > TILES_HIGH - 1) ? RA'(TILES_HIGH - 1) : RA'(cmd.bottom_row);
    mark_empty = (c0 > c1) || (r0 > r1);
    for (int i = 0; i < TILES_WIDE; i++) begin
      mask_new[i] = (COL_W'(i) >= c0) && (COL_W'(i) <= c1);
    end
    scan_oob = int'(cmd.scan_row) >= TILES_HIGH;
    base_new = TILE_W'(int'(cmd.scan_row) * TILES_WIDE);
  end

  // row memory access
  always_comb begin
    mem_ctl.we  = pend && ((state == S_MARK) || (state == S_MARK_LAST));
    mem_ctl.clr = (state == S_SCAN_LOAD);
    rd_addr     = (state == S_MARK) ? cur_row : row_q;
    wr_addr     = (state == S_SCAN_LOAD) ? row_q : pend_row;
    wr_data     = rd_data | mark_mask;
  end

  dtrt_row_store #(
    .TILES_WIDE (TILES_WIDE),
    .TILES_HIGH (TILES_HIGH),
    .RA         (RA)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .ctl     (mem_ctl),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  assign scan_start = (state == S_SCAN_LOAD) && (rd_data != '0);

  dtrt_run_scan #(
    .TILES_WIDE (TILES_WIDE)
  ) u_scan (
    .clk   (clk),
    .rst   (rst),
    .start (scan_start),
    .bits  (rd_data),
    .take  (out_free),
    .found (scan_found),
    .run   (scan_run)
  );

  // output register handshake
  assign out_free  = !out_valid || run.ready;
  assign out_load  = (state == S_EMPTY) || ((state == S_SCAN_RUN) && scan_found);
  assign cmd.ready = (state == S_IDLE);

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (out_free && out_load) begin
      if (state == S_EMPTY) begin
        out_tile  <= base_q;
        out_len   <= '0;
        out_empty <= 1'b1;
        out_last  <= 1'b1;
      end else begin
        out_tile  <= TILE_W'(base_q + TILE_W'(scan_run.start));
        out_len   <= scan_run.length;
        out_empty <= 1'b0;
        out_last  <= scan_run.last;
      end
    end
    if ((state == S_IDLE) && cmd.valid) begin
      cur_row   <= r0;
      end_row   <= r1;
      mark_mask <= mask_new;
      row_q     <= RA'(cmd.scan_row);
      base_q    <= scan_oob ? '0 : base_new;
    end
    if (rst) begin
      state     <= S_IDLE;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid <= out_load;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            if (cmd.command == CMD_MARK) begin
              if (!mark_empty) begin
                state <= S_MARK;
              end
            end else if (scan_oob) begin
              state <= S_EMPTY;
            end else begin
              state <= S_SCAN_RD;
            end
          end
        end
        S_MARK: begin
          pend     <= 1'b1;
          pend_row <= cur_row;
          if (cur_row == end_row) begin
            state <= S_MARK_LAST;
          end else begin
            cur_row <= RA'(cur_row + RA'(1));
          end
        end
        S_MARK_LAST: begin
          pend  <= 1'b0;
          state <= S_IDLE;
        end
        S_SCAN_RD: begin
          state <= S_SCAN_LOAD;
        end
        S_SCAN_LOAD: begin
          state <= (rd_data == '0) ? S_EMPTY : S_SCAN_RUN;
        end
        S_SCAN_RUN: begin
          if (scan_found && scan_run.last && out_free) begin
            state <= S_IDLE;
          end
        end
        S_EMPTY: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign run.valid          = out_valid;
  assign run.run_first_tile = out_tile;
  assign run.run_length     = out_len;
  assign run.row_empty      = out_empty;
  assign run.last_run       = out_last;

endmodule

// ===== rtl/dtrt_row_store.sv =====
module dtrt_row_store #(
  parameter int TILES_WIDE = dtrt_pkg::DEF_TILES_WIDE,
  parameter int TILES_HIGH = dtrt_pkg::DEF_TILES_HIGH,
  parameter int RA         = (TILES_HIGH > 1) ? $clog2(TILES_HIGH) : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  dtrt_pkg::mem_ctl_t    ctl,
  input  logic [RA-1:0]         rd_addr,
  input  logic [RA-1:0]         wr_addr,
  input  logic [TILES_WIDE-1:0] wr_data,
  output logic [TILES_WIDE-1:0] rd_data
);
  import dtrt_pkg::*;

  logic [TILES_WIDE-1:0] mem [TILES_HIGH];
  logic [TILES_HIGH-1:0] row_valid;
  logic [TILES_WIDE-1:0] rd_q;
  logic                  rd_valid_q;

  // row memory, registered read
  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q       <= mem[rd_addr];
    rd_valid_q <= row_valid[rd_addr];
  end

  // per-row valid bits, a row that is not valid reads as clean
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (ctl.we) begin
      row_valid[wr_addr] <= 1'b1;
    end else if (ctl.clr) begin
      row_valid[wr_addr] <= 1'b0;
    end
  end

  assign rd_data = rd_valid_q ? rd_q : '0;

endmodule

// ===== rtl/dtrt_run_scan.sv =====
module dtrt_run_scan #(
  parameter int TILES_WIDE = dtrt_pkg::DEF_TILES_WIDE
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [TILES_WIDE-1:0] bits,
  input  logic                  take,
  output logic                  found,
  output dtrt_pkg::run_t        run
);
  import dtrt_pkg::*;

  logic [TILES_WIDE-1:0] sr;
  logic [TILES_WIDE-1:0] next_sr;
  logic [COL_W-1:0]      col;
  logic [COL_W-1:0]      run_start;
  logic [LEN_W-1:0]      run_len;
  logic                  in_run;
  logic                  active;

  // bit 0 of the shift register is the current column
  always_comb begin
    next_sr    = sr >> 1;
    found      = active && sr[0] && !next_sr[0];
    run.start  = in_run ? run_start : col;
    run.length = in_run ? LEN_W'(run_len + LEN_W'(1)) : LEN_W'(1);
    run.last   = (next_sr == '0);
  end

  // one column per cycle, hold while a finished run cannot be taken
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      in_run <= 1'b0;
    end else if (start) begin
      active <= 1'b1;
      in_run <= 1'b0;
      sr     <= bits;
      col    <= '0;
    end else if (active && (!found || take)) begin
      sr  <= next_sr;
      col <= COL_W'(col + COL_W'(1));
      if (found) begin
        in_run <= 1'b0;
        if (run.last) begin
          active <= 1'b0;
        end
      end else if (sr[0]) begin
        if (!in_run) begin
          in_run    <= 1'b1;
          run_start <= col;
          run_len   <= LEN_W'(1);
        end else begin
          run_len <= LEN_W'(run_len + LEN_W'(1));
        end
      end
    end
  end

endmodule

// ===== rtl/dtrt_checker.sv =====
module dtrt_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        cmd_valid,
  input logic                        cmd_ready,
  input logic                        cmd_command,
  input logic                        run_valid,
  input logic                        run_ready,
  input logic [dtrt_pkg::TILE_W-1:0] run_first_tile,
  input logic [dtrt_pkg::LEN_W-1:0]  run_length,
  input logic                        run_row_empty,
  input logic                        run_last_run
);
  import dtrt_pkg::*;

  // a waiting result holds until taken
  assert property (@(posedge clk) disable iff (rst)
    run_valid && !run_ready |=> run_valid && $stable(run_first_tile)
      && $stable(run_length) && $stable(run_row_empty) && $stable(run_last_run))
    else $error("run item changed while stalled");

  // a scan blocks the next command
  assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready && (cmd_command == CMD_SCAN) |=> !cmd_ready)
    else $error("command taken during a scan");

  // an empty row result is a single zero-length item
  assert property (@(posedge clk) disable iff (rst)
    run_valid && run_row_empty |-> run_last_run && (run_length == '0))
    else $error("empty row result malformed");

  // reset leaves no result and an open command port
  assert property (@(posedge clk)
    rst |=> !run_valid && cmd_ready)
    else $error("state not cleared by reset");

endmodule

bind dirty_tile_run_tracker dtrt_checker u_dtrt_checker (
  .clk            (clk),
  .rst            (rst),
  .cmd_valid      (cmd.valid),
  .cmd_ready      (cmd.ready),
  .cmd_command    (cmd.command),
  .run_valid      (run.valid),
  .run_ready      (run.ready),
  .run_first_tile (run.run_first_tile),
  .run_length     (run.run_length),
  .run_row_empty  (run.row_empty),
  .run_last_run   (run.last_run)
);
